// ----- design/toeq_pkg.sv -----
package toeq_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_POP
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic    load_out;
    act_t    act;
    status_t status;
    logic    cancel;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one;
  } dp_sts_t;

endpackage

// ----- design/toeq_ctrl.sv -----
module toeq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_operation,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  toeq_pkg::dp_sts_t sts,
  output toeq_pkg::dp_cmd_t cmd
);

  toeq_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == toeq_pkg::ST_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      toeq_pkg::ST_IDLE: begin
        if (accept && (in_operation == toeq_pkg::OP_CLEAR) && !sts.empty && !sts.one) begin
          state_nxt = toeq_pkg::ST_CLEAR;
        end
      end
      toeq_pkg::ST_CLEAR: begin
        if (out_free && sts.one) begin
          state_nxt = toeq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = toeq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load_out = 1'b0;
    cmd.act      = toeq_pkg::ACT_HOLD;
    cmd.status   = toeq_pkg::STS_OK;
    cmd.cancel   = 1'b0;
    unique case (state_r)
      toeq_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.load_out = 1'b1;
          case (in_operation)
            toeq_pkg::OP_INSERT: begin
              if (sts.full) begin
                cmd.status = toeq_pkg::STS_FULL;
              end else begin
                cmd.act = toeq_pkg::ACT_INSERT;
              end
            end
            toeq_pkg::OP_POP: begin
              if (sts.empty) begin
                cmd.status = toeq_pkg::STS_EMPTY;
              end else begin
                cmd.act = toeq_pkg::ACT_POP;
              end
            end
            toeq_pkg::OP_CLEAR: begin
              if (!sts.empty) begin
                cmd.act    = toeq_pkg::ACT_POP;
                cmd.cancel = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      toeq_pkg::ST_CLEAR: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.act      = toeq_pkg::ACT_POP;
          cmd.cancel   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= toeq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/toeq_datapath.sv -----
module toeq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 16,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned KW = (HANDLE_BITS < toeq_pkg::ID_W) ? HANDLE_BITS : toeq_pkg::ID_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  toeq_pkg::dp_cmd_t            cmd,
  output toeq_pkg::dp_sts_t            sts,
  input  logic [toeq_pkg::ID_W-1:0]    in_event_id,
  input  logic [toeq_pkg::TIME_W-1:0]  in_event_time,
  output logic [1:0]                   out_status,
  output logic                         out_head_valid,
  output logic [toeq_pkg::ID_W-1:0]    out_head_id,
  output logic [toeq_pkg::TIME_W-1:0]  out_head_time,
  output logic [CW-1:0]                out_occupancy,
  output logic                         out_cancel_valid,
  output logic [toeq_pkg::ID_W-1:0]    out_cancel_id,
  output logic                         out_last
);

  logic [KW-1:0]               handle_r   [QUEUE_DEPTH];
  logic [KW-1:0]               handle_nxt [QUEUE_DEPTH];
  logic [toeq_pkg::TIME_W-1:0] time_r     [QUEUE_DEPTH];
  logic [toeq_pkg::TIME_W-1:0] time_nxt   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      take_new;
  logic [CW-1:0]               count_r, count_nxt;
  logic [KW-1:0]               new_id;

  logic [1:0]                  status_r;
  logic                        head_valid_r;
  logic [toeq_pkg::ID_W-1:0]   head_id_r;
  logic [toeq_pkg::TIME_W-1:0] head_time_r;
  logic [CW-1:0]               occ_r;
  logic                        cancel_valid_r;
  logic [toeq_pkg::ID_W-1:0]   cancel_id_r;
  logic                        last_r;

  assign new_id    = in_event_id[KW-1:0];
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(QUEUE_DEPTH));
  assign sts.one   = (count_r == CW'(1));

  // slot takes the new word at or after the first strictly later time
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    assign take_new[i] = (CW'(i) >= count_r) || (time_r[i] > in_event_time);

    always_comb begin
      handle_nxt[i] = handle_r[i];
      time_nxt[i]   = time_r[i];
      case (cmd.act)
        toeq_pkg::ACT_INSERT: begin
          if ((i > 0) && take_new[(i > 0) ? i - 1 : 0]) begin
            handle_nxt[i] = handle_r[(i > 0) ? i - 1 : 0];
            time_nxt[i]   = time_r[(i > 0) ? i - 1 : 0];
          end else if (take_new[i]) begin
            handle_nxt[i] = new_id;
            time_nxt[i]   = in_event_time;
          end
        end
        toeq_pkg::ACT_POP: begin
          if (i < QUEUE_DEPTH - 1) begin
            handle_nxt[i] = handle_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            time_nxt[i]   = time_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          end
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      handle_r[i] <= handle_nxt[i];
      time_r[i]   <= time_nxt[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    case (cmd.act)
      toeq_pkg::ACT_INSERT: count_nxt = count_r + CW'(1);
      toeq_pkg::ACT_POP:    count_nxt = count_r - CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r       <= cmd.status;
      head_valid_r   <= (count_nxt != '0);
      head_id_r      <= (count_nxt != '0) ? toeq_pkg::ID_W'(handle_nxt[0]) : '0;
      head_time_r    <= (count_nxt != '0) ? time_nxt[0] : '0;
      occ_r          <= count_nxt;
      cancel_valid_r <= cmd.cancel;
      cancel_id_r    <= cmd.cancel ? toeq_pkg::ID_W'(handle_r[0]) : '0;
      last_r         <= !cmd.cancel || sts.one;
    end
  end

  assign out_status       = status_r;
  assign out_head_valid   = head_valid_r;
  assign out_head_id      = head_id_r;
  assign out_head_time    = head_time_r;
  assign out_occupancy    = occ_r;
  assign out_cancel_valid = cancel_valid_r;
  assign out_cancel_id    = cancel_id_r;
  assign out_last         = last_r;

endmodule

// ----- design/time_ordered_event_queue.sv -----
// Sorted event queue of up to QUEUE_DEPTH (handle, 64-bit time) entries held
// in a row of slot registers, earliest time at the head; equal times leave in
// arrival order. On an insert every slot compares its time with the new one
// in parallel, and an insert or pop shifts the row by one place. The result
// sits in an output register, and a new word is taken once that register is
// empty or draining and no clear runs, so with out_stall low one insert or pop
// is accepted every cycle. Clear streams one cancel word per held entry, one
// per cycle, with in_stall high until the last one is loaded. A full insert
// or empty pop leaves the queue untouched and reports it in out_status.
module time_ordered_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 16,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_operation,
  input  logic [toeq_pkg::ID_W-1:0]    in_event_id,
  input  logic [toeq_pkg::TIME_W-1:0]  in_event_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic                         out_head_valid,
  output logic [toeq_pkg::ID_W-1:0]    out_head_id,
  output logic [toeq_pkg::TIME_W-1:0]  out_head_time,
  output logic [CW-1:0]                out_occupancy,
  output logic                         out_cancel_valid,
  output logic [toeq_pkg::ID_W-1:0]    out_cancel_id,
  output logic                         out_last
);

  toeq_pkg::dp_cmd_t cmd;
  toeq_pkg::dp_sts_t sts;

  toeq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  toeq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_event_id      (in_event_id),
    .in_event_time    (in_event_time),
    .out_status       (out_status),
    .out_head_valid   (out_head_valid),
    .out_head_id      (out_head_id),
    .out_head_time    (out_head_time),
    .out_occupancy    (out_occupancy),
    .out_cancel_valid (out_cancel_valid),
    .out_cancel_id    (out_cancel_id),
    .out_last         (out_last)
  );

endmodule

// ----- design/toeq_checker.sv -----
module toeq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_head_valid,
  input logic [toeq_pkg::ID_W-1:0]    out_head_id,
  input logic [toeq_pkg::TIME_W-1:0]  out_head_time,
  input logic [CW-1:0]                out_occupancy,
  input logic                         out_cancel_valid,
  input logic [toeq_pkg::ID_W-1:0]    out_cancel_id,
  input logic                         out_last
);

  a_head_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == (out_occupancy != '0)))
    else $error("head_valid disagrees with occupancy");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_head_valid) |-> (out_head_id == '0) && (out_head_time == '0))
    else $error("empty queue reports a nonzero head");

  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cancel_valid && out_last) |-> (out_occupancy == '0))
    else $error("final cancel word leaves entries behind");

  a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_cancel_valid) |-> out_last && (out_cancel_id == '0))
    else $error("non-cancel word is not final");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_occupancy) && $stable(out_cancel_id))
    else $error("stalled word changed");

endmodule

bind time_ordered_event_queue toeq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_toeq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_head_valid   (out_head_valid),
  .out_head_id      (out_head_id),
  .out_head_time    (out_head_time),
  .out_occupancy    (out_occupancy),
  .out_cancel_valid (out_cancel_valid),
  .out_cancel_id    (out_cancel_id),
  .out_last         (out_last)
);
